// ===== design/hdrf_pkg.sv =====
// ----------------------------------------------------------------------------
// hdrf_pkg
// Request and result types of the hashed duplicate record filter.
// ----------------------------------------------------------------------------
package hdrf_pkg;

    localparam int NAME_BYTES = 9;
    localparam int HASH_W     = 32;
    localparam int HASH_MULT  = 31;

    typedef struct packed {
        logic [63:0]        name_low;
        logic [7:0]         name_high;
        logic signed [31:0] age;
        logic signed [31:0] weight;
        logic               first;
    } t_req;

    typedef struct packed {
        logic keep;
        logic not_remembered;
    } t_res;

endpackage

// ===== design/hashed_duplicate_record_filter.sv =====
// ----------------------------------------------------------------------------
// hashed_duplicate_record_filter
// Drops records already seen since the last start of a list, using a chained
// hash set kept in a bucket head memory and an entry pool memory.
// ----------------------------------------------------------------------------
// steps: name bytes hashed through the first zero, modulo one hash byte at a
//   time when BUCKETS is not a power of two, head read request and head read,
//   one compare per chain entry and an insert; o_strobe comes next cycle
// busy is high all that time and drops with o_strobe, so a new request waits
//   for the last; first adds a head clearing pass over all BUCKETS heads,
//   also run after reset. reset: synchronous, active low; never stalled
module hashed_duplicate_record_filter
    import hdrf_pkg::*;
#(
    parameter int BUCKETS = 128,
    parameter int ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(ENTRIES + 1);
    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    // modulo one hash byte at a time: x = rem*256 + byte, x < 2**MX_W
    localparam int MX_W  = BW + 8;
    localparam int MOD_S = MX_W + $clog2(BUCKETS);
    localparam logic [MX_W+1:0] MOD_M =
        (MX_W+2)'(((64'd1 << MOD_S) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_HREQ  = 3'd4;
    localparam logic [2:0] S_HEAD  = 3'd5;
    localparam logic [2:0] S_CMP   = 3'd6;
    localparam logic [2:0] S_INS   = 3'd7;

    typedef struct packed {
        logic [NAME_BYTES*8-1:0] name;
        logic [31:0]             age;
        logic [31:0]             weight;
        logic [PW-1:0]           link;
    } t_entry;

    logic [2:0]              r_state, n_state;
    logic                    r_pending, n_pending;
    logic [BW-1:0]           r_clr, n_clr;
    logic [3:0]              r_bi, n_bi;
    logic [1:0]              r_bit, n_bit;
    logic [HASH_W-1:0]       r_hash, n_hash;
    logic [BW-1:0]           r_rem, n_rem;
    logic [BW-1:0]           r_bucket, n_bucket;
    logic [PW-1:0]           r_used, n_used;
    logic [NAME_BYTES*8-1:0] r_name, n_name;
    logic [31:0]             r_age, n_age;
    logic [31:0]             r_weight, n_weight;
    logic                    r_strobe, n_strobe;
    t_res                    r_res, n_res;

    logic [PW-1:0] r_heads [BUCKETS];
    logic [PW-1:0] r_head_q;
    t_entry        r_ents [ENTRIES];
    t_entry        r_ent_q;

    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [PW-1:0] head_wd;
    logic          ent_we;
    t_entry        ent_wd;
    logic [EW-1:0] ent_ra;
    logic [PW-1:0] ptr_m1;

    logic [NAME_BYTES*8-1:0] raw_name;
    logic [NAME_BYTES*8-1:0] cut_name;
    logic                    alive;
    logic [7:0]              cur_byte;
    logic [HASH_W-1:0]       step_hash;
    logic [MX_W-1:0]         mod_x;
    logic [2*MX_W+1:0]       mod_prod;
    logic [7:0]              mod_q;
    logic [MX_W-1:0]         mod_rem;
    logic                    ent_match;
    logic                    accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // name ends at its first zero byte
    always_comb begin
        raw_name = {i_req.name_high, i_req.name_low};
        cut_name = '0;
        alive    = 1'b1;
        for (int i = 0; i < NAME_BYTES; i++) begin
            alive = alive && (raw_name[i*8 +: 8] != 8'd0);
            if (alive) begin
                cut_name[i*8 +: 8] = raw_name[i*8 +: 8];
            end
        end
    end

    // shared unit: h*31 + byte, and the per byte modulo by reciprocal
    assign cur_byte  = r_name[r_bi*8 +: 8];
    assign step_hash = {r_hash[HASH_W-6:0], 5'd0} - r_hash + {24'd0, cur_byte};
    assign mod_x     = {r_rem, r_hash[HASH_W-1 -: 8]};
    assign mod_prod  = (2*MX_W+2)'(mod_x) * (2*MX_W+2)'(MOD_M);
    assign mod_q     = mod_prod[MOD_S +: 8];
    assign mod_rem   = mod_x - MX_W'(mod_q) * MX_W'(BUCKETS);

    assign ent_match = (r_ent_q.name == r_name) && (r_ent_q.age == r_age)
                       && (r_ent_q.weight == r_weight);

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_clr     = r_clr;
        n_bi      = r_bi;
        n_bit     = r_bit;
        n_hash    = r_hash;
        n_rem     = r_rem;
        n_bucket  = r_bucket;
        n_used    = r_used;
        n_name    = r_name;
        n_age     = r_age;
        n_weight  = r_weight;
        n_strobe  = 1'b0;
        n_res     = r_res;
        head_we   = 1'b0;
        head_wa   = r_bucket;
        head_wd   = r_used + 1'b1;
        ent_we    = 1'b0;
        ent_wd    = '{name: r_name, age: r_age, weight: r_weight, link: r_head_q};
        ptr_m1    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_name   = cut_name;
                    n_age    = i_req.age;
                    n_weight = i_req.weight;
                    n_hash   = '0;
                    n_bi     = '0;
                    if (i_req.first) begin
                        n_used    = '0;
                        n_clr     = '0;
                        n_pending = 1'b1;
                        n_state   = S_CLEAR;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_pending = 1'b0;
                    n_state   = r_pending ? S_HASH : S_IDLE;
                end
            end
            S_HASH: begin
                if (cur_byte != 8'd0) begin
                    n_hash = step_hash;
                end
                n_bi = r_bi + 1'b1;
                if (cur_byte == 8'd0 || r_bi == 4'(NAME_BYTES - 1)) begin
                    if (IS_POW2) begin
                        n_bucket = (BUCKETS == 1) ? '0 : n_hash[BW-1:0];
                        n_state  = S_HREQ;
                    end else begin
                        n_rem   = '0;
                        n_bit   = '0;
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // top hash byte first
                n_hash = {r_hash[HASH_W-9:0], 8'd0};
                n_rem  = mod_rem[BW-1:0];
                n_bit  = r_bit + 1'b1;
                if (r_bit == 2'd3) begin
                    n_bucket = n_rem;
                    n_state  = S_HREQ;
                end
            end
            S_HREQ: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                ptr_m1 = r_head_q - 1'b1;
                n_state = (r_head_q == '0) ? S_INS : S_CMP;
            end
            S_CMP: begin
                ptr_m1 = r_ent_q.link - 1'b1;
                if (ent_match) begin
                    n_strobe = 1'b1;
                    n_res    = '{keep: 1'b0, not_remembered: 1'b0};
                    n_state  = S_IDLE;
                end else if (r_ent_q.link == '0) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_used >= PW'(ENTRIES)) begin
                    n_res = '{keep: 1'b1, not_remembered: 1'b1};
                end else begin
                    n_res   = '{keep: 1'b1, not_remembered: 1'b0};
                    head_we = 1'b1;
                    ent_we  = 1'b1;
                    n_used  = r_used + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        ent_ra = ptr_m1[EW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pending <= 1'b0;
            r_clr     <= '0;
            r_used    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_clr     <= n_clr;
            r_used    <= n_used;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bi     <= n_bi;
        r_bit    <= n_bit;
        r_hash   <= n_hash;
        r_rem    <= n_rem;
        r_bucket <= n_bucket;
        r_name   <= n_name;
        r_age    <= n_age;
        r_weight <= n_weight;
        r_res    <= n_res;
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_heads[head_wa] <= head_wd;
        end
        r_head_q <= r_heads[r_bucket];
    end

    // entry pool memory
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ents[r_used[EW-1:0]] <= ent_wd;
        end
        r_ent_q <= r_ents[ent_ra];
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_CMP || $past(r_state) == S_INS))
        else $error("result strobe without a finished lookup");

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.first) |=> (r_state == S_CLEAR && r_used == '0))
        else $error("list start did not clear the set");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && r_used < PW'(ENTRIES)) |=> (r_used == $past(r_used) + 1'b1))
        else $error("insert did not take a pool entry");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still busy");
`endif

endmodule
